>>> hdl/c2m_pkg.sv
// Package for the charge-to-multipole coefficient core.
// Holds payload structs, the sign-magnitude value type and its helper functions.
// No dependencies.
package c2m_pkg;

  localparam int CoefFracBits = 24;
  localparam int MaxOrder     = 7;
  localparam int CoefW        = 48;

  localparam logic [62:0] MagLim = '1;
  localparam logic [62:0] OutMax = 63'(48'h7FFF_FFFF_FFFF);

  typedef struct packed {
    logic        neg;
    logic [62:0] mag;
  } c2m_fx_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic               is_placeholder;
    logic               final_charge;
  } c2m_in_t;

  typedef struct packed {
    logic        [5:0]       term_index;
    logic signed [CoefW-1:0] coefficient;
    logic                    last_term;
    logic                    last_of_cube;
  } c2m_out_t;

  typedef struct packed {
    c2m_fx_t    dx;
    c2m_fx_t    dy;
    c2m_fx_t    dz;
    logic       dummy;
    logic       fin;
    logic [2:0] order;
  } c2m_job_t;

  typedef enum logic [1:0] {
    OP_MULF = 2'd0,
    OP_MULI = 2'd1,
    OP_DIV  = 2'd2
  } c2m_op_e;

  typedef enum logic [1:0] {
    REG_CX    = 2'd0,
    REG_CY    = 2'd1,
    REG_CZ    = 2'd2,
    REG_ORDER = 2'd3
  } c2m_reg_e;

  function automatic c2m_fx_t fx_make(input logic neg, input logic [63:0] mag);
    c2m_fx_t r;
    r.mag = mag[63] ? MagLim : mag[62:0];
    r.neg = neg & (|r.mag);
    return r;
  endfunction

  function automatic c2m_fx_t fx_neg(input c2m_fx_t a);
    return fx_make(!a.neg, {1'b0, a.mag});
  endfunction

  function automatic c2m_fx_t fx_add(input c2m_fx_t a, input c2m_fx_t b);
    c2m_fx_t r;
    if (a.neg == b.neg) begin
      r = fx_make(a.neg, {1'b0, a.mag} + {1'b0, b.mag});
    end else if (a.mag >= b.mag) begin
      r = fx_make(a.neg, {1'b0, a.mag - b.mag});
    end else begin
      r = fx_make(b.neg, {1'b0, b.mag - a.mag});
    end
    return r;
  endfunction

  function automatic logic [CoefW-1:0] out_bits(input c2m_fx_t a);
    logic [CoefW-1:0] r;
    if (a.neg) begin
      if (a.mag > OutMax + 63'd1) begin
        r = {1'b1, {(CoefW-1){1'b0}}};
      end else begin
        r = CoefW'(63'd0 - a.mag);
      end
    end else begin
      r = (a.mag > OutMax) ? OutMax[CoefW-1:0] : a.mag[CoefW-1:0];
    end
    return r;
  endfunction

endpackage

>>> hdl/charge_to_multipole_coefficients_core.sv
// Top level of the charge-to-multipole coefficient core: register port,
// front stage, job queue and back stage. Depends on c2m_pkg and all c2m_* modules.
//
// Usage: write center_x/y/z (0x0, 0x4, 0x8) and expansion_order (0xC) over the
// APB port while idle; reset leaves the center at 0 and the order at 2.
// Raise start with a charge on in_item_i; it is taken when busy is low. Each
// charge yields (order+1)^2 beats on result_o, one per cycle, each marked by
// result_strobe_o, in increasing term_index; last_term flags the final beat.
// Three further charges can be held (front register and two queue slots) while
// one is being evaluated; busy stays high once all of them are full.
// Each charge passes through the front register and the queue, then its products and
// its divisions by (n-m) run one at a time on the shared unit while the sequencer
// steps through each (n,m) term, and then its (order+1)^2 output beats follow. The
// shared multiply and divide unit sets the rate.
// The receiver cannot stall: every beat must be taken in its cycle. Reset
// clears the queue and the sequencer.
module charge_to_multipole_coefficients_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              start,
  output logic              busy,
  input  c2m_pkg::c2m_in_t  in_item_i,
  output c2m_pkg::c2m_out_t result_o,
  output logic              result_strobe_o
);

  logic [31:0] cx_q, cy_q, cz_q;
  logic [2:0]  order_q;
  logic        cfg_wr;
  c2m_pkg::c2m_reg_e reg_sel;

  logic              f_valid, q_ready, q_valid, q_pop;
  c2m_pkg::c2m_job_t f_job, q_job;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign reg_sel = c2m_pkg::c2m_reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q    <= 32'd0;
      cy_q    <= 32'd0;
      cz_q    <= 32'd0;
      order_q <= 3'd2;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        c2m_pkg::REG_CX:    cx_q    <= pwdata;
        c2m_pkg::REG_CY:    cy_q    <= pwdata;
        c2m_pkg::REG_CZ:    cz_q    <= pwdata;
        c2m_pkg::REG_ORDER: order_q <= pwdata[2:0];
        default:            cx_q    <= cx_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      c2m_pkg::REG_CX:    prdata = cx_q;
      c2m_pkg::REG_CY:    prdata = cy_q;
      c2m_pkg::REG_CZ:    prdata = cz_q;
      c2m_pkg::REG_ORDER: prdata = {29'd0, order_q};
      default:            prdata = 32'd0;
    endcase
  end

  c2m_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .item_i     (in_item_i),
    .cx_i       (cx_q),
    .cy_i       (cy_q),
    .cz_i       (cz_q),
    .order_i    (order_q),
    .busy_o     (busy),
    .job_valid_o(f_valid),
    .job_o      (f_job),
    .job_ready_i(q_ready)
  );

  c2m_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (f_valid),
    .data_i (f_job),
    .ready_o(q_ready),
    .valid_o(q_valid),
    .data_o (q_job),
    .pop_i  (q_pop)
  );

  c2m_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (q_valid),
    .job_i          (q_job),
    .job_pop_o      (q_pop),
    .result_o       (result_o),
    .result_strobe_o(result_strobe_o)
  );

endmodule

>>> hdl/c2m_front.sv
// Front stage: accepts a charge, forms the offsets from the center as values.
// Depends on c2m_pkg.
module c2m_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  c2m_pkg::c2m_in_t      item_i,
  input  logic [31:0]           cx_i,
  input  logic [31:0]           cy_i,
  input  logic [31:0]           cz_i,
  input  logic [2:0]            order_i,
  output logic                  busy_o,
  output logic                  job_valid_o,
  output c2m_pkg::c2m_job_t     job_o,
  input  logic                  job_ready_i
);

  logic              valid_q, valid_d;
  logic signed [32:0] dx_q, dy_q, dz_q;
  logic              dummy_q, fin_q;
  logic [2:0]        order_q;
  logic              accept;

  function automatic c2m_pkg::c2m_fx_t to_fx(input logic signed [32:0] d);
    logic [32:0] a;
    a = d[32] ? (33'd0 - d) : d;
    return c2m_pkg::fx_make(d[32], 64'(a) << (c2m_pkg::CoefFracBits - 16));
  endfunction

  assign busy_o = valid_q & !job_ready_i;
  assign accept = start_i & !busy_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (job_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      dx_q    <= {item_i.pos_x[31], item_i.pos_x} - {cx_i[31], cx_i};
      dy_q    <= {item_i.pos_y[31], item_i.pos_y} - {cy_i[31], cy_i};
      dz_q    <= {item_i.pos_z[31], item_i.pos_z} - {cz_i[31], cz_i};
      dummy_q <= item_i.is_placeholder;
      fin_q   <= item_i.final_charge;
      order_q <= order_i;
    end
  end

  assign job_valid_o = valid_q;
  assign job_o.dx    = to_fx(dx_q);
  assign job_o.dy    = to_fx(dy_q);
  assign job_o.dz    = to_fx(dz_q);
  assign job_o.dummy = dummy_q;
  assign job_o.fin   = fin_q;
  assign job_o.order = order_q;

endmodule

>>> hdl/c2m_queue.sv
// Two-entry job queue between front and back stages.
// Depends on c2m_pkg.
module c2m_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  c2m_pkg::c2m_job_t data_i,
  output logic              ready_o,
  output logic              valid_o,
  output c2m_pkg::c2m_job_t data_o,
  input  logic              pop_i
);

  c2m_pkg::c2m_job_t slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign ready_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = slot_q[rd_ptr_q];
  assign do_push = push_i & ready_o;
  assign do_pop  = pop_i & valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop)  rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_ptr_q] <= data_i;
  end

endmodule

>>> hdl/c2m_alu.sv
// Shared multi-cycle arithmetic unit: 63x64 magnitude product from four 32x32
// partial products (fractional or integer scaling), and a radix-2 divider by 2..7.
// Depends on c2m_pkg.
module c2m_alu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  c2m_pkg::c2m_op_e  op_i,
  input  logic [62:0]       a_i,
  input  logic [63:0]       b_i,
  output logic              busy_o,
  output logic              done_o,
  output logic [62:0]       res_o
);

  localparam int F = c2m_pkg::CoefFracBits;

  logic [62:0]       a_q;
  logic [63:0]       b_q;
  logic [127:0]      acc_q, acc_d;
  logic [5:0]        cnt_q;
  c2m_pkg::c2m_op_e  op_q;
  logic              busy_q, busy_d, done_q, done_d;
  logic [62:0]       res_q, res_d;
  logic [2:0]        rem_q, rem_d;

  logic [31:0]  xa, yb;
  logic [63:0]  pp;
  logic [6:0]   shamt;
  logic [127:0] rnd, rnd_sh;
  logic [3:0]   remsh;
  logic         ge;

  assign xa    = cnt_q[1] ? {1'b0, a_q[62:32]} : a_q[31:0];
  assign yb    = cnt_q[0] ? b_q[63:32] : b_q[31:0];
  assign pp    = xa * yb;
  assign shamt = {cnt_q[1] & cnt_q[0], cnt_q[1] ^ cnt_q[0], 5'd0};
  assign rnd    = acc_q + (128'd1 << (F - 1));
  assign rnd_sh = rnd >> F;
  assign remsh  = {rem_q, acc_q[63]};
  assign ge     = remsh >= {1'b0, b_q[2:0]};

  always_comb begin
    acc_d  = acc_q;
    busy_d = busy_q;
    done_d = 1'b0;
    res_d  = res_q;
    rem_d  = rem_q;
    if (!busy_q) begin
      if (start_i) begin
        busy_d = 1'b1;
        rem_d  = 3'd0;
        acc_d  = (op_i == c2m_pkg::OP_DIV) ?
                 128'({1'b0, a_i} + {1'b0, b_i[63:1]}) : 128'd0;
      end
    end else begin
      unique case (op_q)
        c2m_pkg::OP_DIV: begin
          rem_d = ge ? 3'(remsh - {1'b0, b_q[2:0]}) : remsh[2:0];
          acc_d = {64'd0, acc_q[62:0], ge};
          if (cnt_q == 6'd63) begin
            busy_d = 1'b0;
            done_d = 1'b1;
            res_d  = acc_d[62:0];
          end
        end
        c2m_pkg::OP_MULF, c2m_pkg::OP_MULI: begin
          if (cnt_q < 6'd4) begin
            acc_d = acc_q + (128'(pp) << shamt);
          end else begin
            busy_d = 1'b0;
            done_d = 1'b1;
            if (op_q == c2m_pkg::OP_MULF) begin
              res_d = (|rnd_sh[127:63]) ? c2m_pkg::MagLim : rnd_sh[62:0];
            end else begin
              res_d = (|acc_q[127:63]) ? c2m_pkg::MagLim : acc_q[62:0];
            end
          end
        end
        default: begin
          busy_d = 1'b0;
          done_d = 1'b1;
          res_d  = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      if (!busy_q) begin
        cnt_q <= 6'd0;
      end else begin
        cnt_q <= cnt_q + 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    res_q <= res_d;
    rem_q <= rem_d;
    if (!busy_q && start_i) begin
      a_q  <= a_i;
      b_q  <= b_i;
      op_q <= op_i;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

>>> hdl/c2m_back.sv
// Back stage: sequencer that evaluates one column into a coefficient memory
// and streams it out in row order. Depends on c2m_pkg and c2m_alu.
module c2m_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  input  c2m_pkg::c2m_job_t job_i,
  output logic              job_pop_o,
  output c2m_pkg::c2m_out_t result_o,
  output logic              result_strobe_o
);

  typedef enum logic [20:0] {
    ST_IDLE = 21'h000001,
    ST_R2X  = 21'h000002,
    ST_R2Y  = 21'h000004,
    ST_R2Z  = 21'h000008,
    ST_REA  = 21'h000010,
    ST_REB  = 21'h000020,
    ST_IMA  = 21'h000040,
    ST_IMB  = 21'h000080,
    ST_SEL  = 21'h000100,
    ST_S1   = 21'h000200,
    ST_SA   = 21'h000400,
    ST_SB   = 21'h000800,
    ST_SC   = 21'h001000,
    ST_SD   = 21'h002000,
    ST_SE   = 21'h004000,
    ST_CA   = 21'h008000,
    ST_CB   = 21'h010000,
    ST_SNA  = 21'h020000,
    ST_SNB  = 21'h040000,
    ST_NEXT = 21'h080000,
    ST_STRM = 21'h100000
  } c2m_state_e;

  localparam c2m_pkg::c2m_fx_t One  = '{neg: 1'b0, mag: 63'(1) << c2m_pkg::CoefFracBits};
  localparam c2m_pkg::c2m_fx_t Zero = '{neg: 1'b0, mag: 63'd0};

  c2m_state_e st_q, st_d;
  logic       issued_q, issued_d;
  c2m_pkg::c2m_fx_t dx_q, dy_q, dz_q, r2_q, re_q, im_q, s1_q, s2_q, sc_q, t_q, u_q;
  c2m_pkg::c2m_fx_t dx_d, dy_d, dz_d, r2_d, re_d, im_d, s1_d, s2_d, sc_d, t_d, u_d;
  logic [2:0]  m_q, m_d, n_q, n_d, ord_q, ord_d;
  logic [18:0] k2_q, k2_d;
  logic        dummy_q, dummy_d, fin_q, fin_d;
  logic [5:0]  idx_q, idx_d;

  logic              alu_start, alu_busy, alu_done;
  c2m_pkg::c2m_op_e  alu_op;
  logic [62:0]       alu_a, alu_res;
  logic [63:0]       alu_b;
  logic              alu_sign;
  c2m_pkg::c2m_fx_t  rfx;

  logic             wr_en, wr_sin;
  c2m_pkg::c2m_fx_t wr_val;
  logic [5:0]       wr_addr, last_idx;
  logic [7:0]       tri_n, cterms;

  logic [c2m_pkg::CoefW-1:0] coef_mem [64];
  logic [c2m_pkg::CoefW-1:0] rd_data_q;
  logic       rd_en;
  logic       out_valid_q, out_last_q, out_dummy_q;
  logic [5:0] out_idx_q;

  c2m_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(alu_start),
    .op_i   (alu_op),
    .a_i    (alu_a),
    .b_i    (alu_b),
    .busy_o (alu_busy),
    .done_o (alu_done),
    .res_o  (alu_res)
  );

  assign rfx      = c2m_pkg::fx_make(alu_sign, {1'b0, alu_res});
  assign tri_n    = 8'(({5'd0, n_q} * ({5'd0, n_q} + 8'd1)) >> 1);
  assign cterms   = 8'(({5'd0, ord_q} + 8'd1) * ({5'd0, ord_q} + 8'd2) >> 1);
  assign last_idx = 6'(({5'd0, ord_q} + 8'd1) * ({5'd0, ord_q} + 8'd1) - 8'd1);
  assign wr_addr  = wr_sin ? 6'(cterms + {5'd0, m_q} + tri_n - {5'd0, n_q} - 8'd1)
                           : 6'({5'd0, m_q} + tri_n);

  always_comb begin
    alu_op   = c2m_pkg::OP_MULF;
    alu_a    = '0;
    alu_b    = '0;
    alu_sign = 1'b0;
    unique case (st_q)
      ST_R2X: begin alu_a = dx_q.mag; alu_b = {1'b0, dx_q.mag}; end
      ST_R2Y: begin alu_a = dy_q.mag; alu_b = {1'b0, dy_q.mag}; end
      ST_R2Z: begin alu_a = dz_q.mag; alu_b = {1'b0, dz_q.mag}; end
      ST_REA: begin
        alu_a = re_q.mag; alu_b = {1'b0, dx_q.mag}; alu_sign = re_q.neg ^ dx_q.neg;
      end
      ST_REB: begin
        alu_a = im_q.mag; alu_b = {1'b0, dy_q.mag}; alu_sign = im_q.neg ^ dy_q.neg;
      end
      ST_IMA: begin
        alu_a = re_q.mag; alu_b = {1'b0, dy_q.mag}; alu_sign = re_q.neg ^ dy_q.neg;
      end
      ST_IMB: begin
        alu_a = im_q.mag; alu_b = {1'b0, dx_q.mag}; alu_sign = im_q.neg ^ dx_q.neg;
      end
      ST_S1: begin
        alu_op = c2m_pkg::OP_MULI; alu_a = dz_q.mag;
        alu_b = 64'({m_q, 1'b1}); alu_sign = dz_q.neg;
      end
      ST_SA: begin
        alu_a = dz_q.mag; alu_b = {1'b0, s1_q.mag}; alu_sign = dz_q.neg ^ s1_q.neg;
      end
      ST_SB: begin
        alu_op = c2m_pkg::OP_MULI; alu_a = t_q.mag;
        alu_b = 64'({n_q, 1'b0} - 4'd1); alu_sign = t_q.neg;
      end
      ST_SC: begin
        alu_a = r2_q.mag; alu_b = {1'b0, s2_q.mag}; alu_sign = r2_q.neg ^ s2_q.neg;
      end
      ST_SD: begin
        alu_op = c2m_pkg::OP_MULI; alu_a = u_q.mag;
        alu_b = 64'({1'b0, n_q} + {1'b0, m_q} - 4'd1); alu_sign = u_q.neg;
      end
      ST_SE: begin
        alu_op = c2m_pkg::OP_DIV; alu_a = u_q.mag;
        alu_b = 64'(n_q - m_q); alu_sign = u_q.neg;
      end
      ST_CA: begin
        alu_a = sc_q.mag; alu_b = {1'b0, re_q.mag}; alu_sign = sc_q.neg ^ re_q.neg;
      end
      ST_SNA: begin
        alu_a = sc_q.mag; alu_b = {1'b0, im_q.mag}; alu_sign = sc_q.neg ^ im_q.neg;
      end
      ST_CB, ST_SNB: begin
        alu_op = c2m_pkg::OP_MULI; alu_a = t_q.mag;
        alu_b = 64'(k2_q); alu_sign = t_q.neg ^ m_q[0];
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  always_comb begin
    st_d = st_q; issued_d = issued_q;
    dx_d = dx_q; dy_d = dy_q; dz_d = dz_q; r2_d = r2_q; re_d = re_q; im_d = im_q;
    s1_d = s1_q; s2_d = s2_q; sc_d = sc_q; t_d = t_q; u_d = u_q;
    m_d = m_q; n_d = n_q; ord_d = ord_q; k2_d = k2_q;
    dummy_d = dummy_q; fin_d = fin_q; idx_d = idx_q;
    alu_start = 1'b0; job_pop_o = 1'b0;
    wr_en = 1'b0; wr_sin = 1'b0; wr_val = rfx; rd_en = 1'b0;

    if (st_q != ST_IDLE && st_q != ST_SEL && st_q != ST_NEXT && st_q != ST_STRM) begin
      if (!issued_q) begin
        alu_start = 1'b1;
        issued_d  = 1'b1;
      end else if (alu_done) begin
        issued_d = 1'b0;
      end
    end

    unique case (st_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          dx_d = job_i.dx; dy_d = job_i.dy; dz_d = job_i.dz;
          dummy_d = job_i.dummy; fin_d = job_i.fin; ord_d = job_i.order;
          st_d = ST_R2X;
        end
      end
      ST_R2X: if (alu_done) begin r2_d = rfx; st_d = ST_R2Y; end
      ST_R2Y: if (alu_done) begin r2_d = c2m_pkg::fx_add(r2_q, rfx); st_d = ST_R2Z; end
      ST_R2Z: begin
        if (alu_done) begin
          r2_d = c2m_pkg::fx_add(r2_q, rfx);
          m_d = 3'd0; n_d = 3'd0; re_d = One; im_d = Zero; k2_d = 19'd2;
          st_d = ST_SEL;
        end
      end
      ST_REA: if (alu_done) begin t_d = rfx; st_d = ST_REB; end
      ST_REB: if (alu_done) begin
        u_d = c2m_pkg::fx_add(t_q, c2m_pkg::fx_neg(rfx)); st_d = ST_IMA;
      end
      ST_IMA: if (alu_done) begin t_d = rfx; st_d = ST_IMB; end
      ST_IMB: begin
        if (alu_done) begin
          im_d = c2m_pkg::fx_add(t_q, rfx);
          re_d = u_q;
          n_d  = m_q;
          st_d = ST_SEL;
        end
      end
      ST_SEL: begin
        if (n_q == m_q) begin
          sc_d   = One;
          wr_val = One;
          wr_en  = (m_q == 3'd0);
          st_d   = (m_q == 3'd0) ? ST_NEXT : ST_CA;
        end else if (n_q == m_q + 3'd1) begin
          st_d = ST_S1;
        end else begin
          st_d = ST_SA;
        end
      end
      ST_S1, ST_SE: begin
        if (alu_done) begin
          sc_d  = rfx;
          wr_en = (m_q == 3'd0);
          st_d  = (m_q == 3'd0) ? ST_NEXT : ST_CA;
        end
      end
      ST_SA: if (alu_done) begin t_d = rfx; st_d = ST_SB; end
      ST_SB: if (alu_done) begin t_d = rfx; st_d = ST_SC; end
      ST_SC: if (alu_done) begin u_d = rfx; st_d = ST_SD; end
      ST_SD: if (alu_done) begin
        u_d = c2m_pkg::fx_add(t_q, c2m_pkg::fx_neg(rfx)); st_d = ST_SE;
      end
      ST_CA: if (alu_done) begin t_d = rfx; st_d = ST_CB; end
      ST_CB: if (alu_done) begin wr_en = 1'b1; st_d = ST_SNA; end
      ST_SNA: if (alu_done) begin t_d = rfx; st_d = ST_SNB; end
      ST_SNB: if (alu_done) begin wr_en = 1'b1; wr_sin = 1'b1; st_d = ST_NEXT; end
      ST_NEXT: begin
        s2_d = s1_q;
        s1_d = sc_q;
        if (n_q == ord_q) begin
          if (m_q == ord_q) begin
            idx_d = 6'd0;
            st_d  = ST_STRM;
          end else begin
            m_d  = m_q + 3'd1;
            k2_d = 19'(k2_q * {1'b0, m_q, 1'b1} + 23'd0);
            st_d = ST_REA;
          end
        end else begin
          n_d  = n_q + 3'd1;
          st_d = ST_SEL;
        end
      end
      ST_STRM: begin
        rd_en = 1'b1;
        idx_d = idx_q + 6'd1;
        if (idx_q == last_idx) st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      issued_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      issued_q    <= issued_d;
      out_valid_q <= rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q <= dx_d; dy_q <= dy_d; dz_q <= dz_d; r2_q <= r2_d; re_q <= re_d; im_q <= im_d;
    s1_q <= s1_d; s2_q <= s2_d; sc_q <= sc_d; t_q <= t_d; u_q <= u_d;
    m_q <= m_d; n_q <= n_d; ord_q <= ord_d; k2_q <= k2_d;
    dummy_q <= dummy_d; fin_q <= fin_d; idx_q <= idx_d;
    out_idx_q   <= idx_q;
    out_last_q  <= (idx_q == last_idx);
    out_dummy_q <= dummy_q;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) coef_mem[wr_addr] <= c2m_pkg::out_bits(wr_val);
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) rd_data_q <= coef_mem[idx_q];
  end

  assign result_strobe_o       = out_valid_q;
  assign result_o.term_index   = out_idx_q;
  assign result_o.coefficient  = out_dummy_q ? '0 : rd_data_q;
  assign result_o.last_term    = out_last_q;
  assign result_o.last_of_cube = out_last_q & fin_q;

  a_alu_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_start |-> !alu_busy) else $error("alu started while busy");
  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_last_q) |=> !out_valid_q) else $error("beat after last term");
  a_first_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> (out_idx_q == 6'd0)) else $error("column not from row 0");

endmodule

>>> sim/tb.sv
// Testbench for charge_to_multipole_coefficients_core: APB register writes, directed and random
// charges over start/busy, and a scoreboard with its own multipole-column predictor.
// Depends on c2m_pkg and the core RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import c2m_pkg::*;

  localparam int FracBits = 24;
  localparam logic [63:0] MagMax = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] CoefMax = 64'h0000_7FFF_FFFF_FFFF;

  typedef struct {
    bit        neg;
    bit [63:0] mag;
  } sm_t;

  class coef_scoreboard;
    bit [31:0]  ctr_x, ctr_y, ctr_z;
    bit [2:0]   order = 3'd2;
    c2m_out_t   pending[$];
    int         errors;
    int         beats;
    int         charges;

    function sm_t mk(bit neg, bit [63:0] mag);
      sm_t r;
      if (mag > MagMax) mag = MagMax;
      r.neg = neg && mag != 0;
      r.mag = mag;
      return r;
    endfunction

    function sm_t add(sm_t a, sm_t b);
      if (a.neg == b.neg) return mk(a.neg, a.mag + b.mag);
      if (a.mag >= b.mag) return mk(a.neg, a.mag - b.mag);
      return mk(b.neg, b.mag - a.mag);
    endfunction

    function sm_t neg_of(sm_t a);
      return mk(!a.neg, a.mag);
    endfunction

    function sm_t mul(sm_t a, sm_t b);
      bit [127:0] p;
      bit [127:0] q;
      p = a.mag * b.mag;
      q = (p + (128'd1 << (FracBits - 1))) >> FracBits;
      if (q > {64'd0, MagMax}) return mk(a.neg != b.neg, MagMax);
      return mk(a.neg != b.neg, q[63:0]);
    endfunction

    function sm_t muli(sm_t a, bit [63:0] k);
      if (k != 0 && a.mag > MagMax / k) return mk(a.neg, MagMax);
      return mk(a.neg, a.mag * k);
    endfunction

    function sm_t divi(sm_t a, bit [63:0] k);
      return mk(a.neg, (a.mag + k / 2) / k);
    endfunction

    function sm_t offset(bit [31:0] p, bit [31:0] c);
      longint d;
      d = longint'($signed(p)) - longint'($signed(c));
      if (d < 0) return mk(1'b1, 64'(-d) << (FracBits - 16));
      return mk(1'b0, 64'(d) << (FracBits - 16));
    endfunction

    function bit [47:0] to_coef(sm_t v);
      bit [63:0] m;
      m = v.mag;
      if (v.neg) begin
        if (m > CoefMax + 1) m = CoefMax + 1;
        return 48'(64'd0 - m);
      end
      if (m > CoefMax) m = CoefMax;
      return m[47:0];
    endfunction

    function void write_reg(c2m_reg_e idx, bit [31:0] v);
      case (idx)
        REG_CX: ctr_x = v;
        REG_CY: ctr_y = v;
        REG_CZ: ctr_z = v;
        REG_ORDER: order = v[2:0];
      endcase
    endfunction

    function void note_charge(c2m_in_t c);
      sm_t dx, dy, dz, r2, zero, one, t1, t2, cv, sv_;
      sm_t s[8][8];
      sm_t re[8], im[8];
      sm_t cc[8][8], ss[8][8];
      bit [63:0] dfac;
      int ord, nterms, idx;
      c2m_out_t o;
      ord = int'(order);
      nterms = (ord + 1) * (ord + 1);
      zero = mk(1'b0, 64'd0);
      one = mk(1'b0, 64'd1 << FracBits);
      dx = offset(c.pos_x, ctr_x);
      dy = offset(c.pos_y, ctr_y);
      dz = offset(c.pos_z, ctr_z);
      r2 = add(add(mul(dx, dx), mul(dy, dy)), mul(dz, dz));
      re[0] = one;
      im[0] = zero;
      for (int m = 1; m <= ord; m++) begin
        re[m] = add(mul(re[m-1], dx), neg_of(mul(im[m-1], dy)));
        im[m] = add(mul(re[m-1], dy), mul(im[m-1], dx));
      end
      dfac = 64'd1;
      for (int m = 0; m <= ord; m++) begin
        if (m > 0) dfac = dfac * 64'(2 * m - 1);
        for (int n = m; n <= ord; n++) begin
          if (n == m) s[n][m] = one;
          else if (n == m + 1) s[n][m] = muli(dz, 64'(2 * m + 1));
          else begin
            t1 = muli(mul(dz, s[n-1][m]), 64'(2 * n - 1));
            t2 = muli(mul(r2, s[n-2][m]), 64'(n + m - 1));
            s[n][m] = divi(add(t1, neg_of(t2)), 64'(n - m));
          end
          if (c.is_placeholder) begin
            cc[n][m] = zero;
            ss[n][m] = zero;
          end else if (m == 0) begin
            cc[n][m] = s[n][m];
            ss[n][m] = zero;
          end else begin
            cv = muli(mul(s[n][m], re[m]), 64'd2 * dfac);
            sv_ = muli(mul(s[n][m], im[m]), 64'd2 * dfac);
            if (m % 2 == 1) begin
              cv = neg_of(cv);
              sv_ = neg_of(sv_);
            end
            cc[n][m] = cv;
            ss[n][m] = sv_;
          end
        end
      end
      idx = 0;
      for (int n = 0; n <= ord; n++) begin
        for (int m = 0; m <= n; m++) begin
          o.term_index = 6'(idx);
          o.coefficient = to_coef(cc[n][m]);
          o.last_term = (idx == nterms - 1);
          o.last_of_cube = o.last_term & c.final_charge;
          pending.push_back(o);
          idx++;
        end
      end
      for (int n = 1; n <= ord; n++) begin
        for (int m = 1; m <= n; m++) begin
          o.term_index = 6'(idx);
          o.coefficient = to_coef(ss[n][m]);
          o.last_term = (idx == nterms - 1);
          o.last_of_cube = o.last_term & c.final_charge;
          pending.push_back(o);
          idx++;
        end
      end
      charges++;
    endfunction

    function void check_beat(c2m_out_t got);
      c2m_out_t want;
      beats++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected beat %p", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.term_index !== want.term_index)
        $display("%0t: term_index exp %0d got %0d", $time, want.term_index, got.term_index);
      if (got.coefficient !== want.coefficient)
        $display("%0t: coefficient (term %0d) exp %h got %h", $time, want.term_index,
                 want.coefficient, got.coefficient);
      if (got.last_term !== want.last_term)
        $display("%0t: last_term exp %b got %b", $time, want.last_term, got.last_term);
      if (got.last_of_cube !== want.last_of_cube)
        $display("%0t: last_of_cube exp %b got %b", $time, want.last_of_cube,
                 got.last_of_cube);
      if (got !== want) errors++;
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic start = 1'b0;
  logic busy;
  c2m_in_t in_item_i = '0;
  c2m_out_t result_o;
  logic result_strobe_o;

  coef_scoreboard sb = new();
  bit quiet;

  charge_to_multipole_coefficients_core dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_strobe_o) sb.check_beat(result_o);
  end

  initial begin
    #400ms;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic reg_write(c2m_reg_e idx, logic [31:0] v);
    @(negedge clk_i);
    psel = 1'b1;
    pwrite = 1'b1;
    paddr = 4'(idx) << 2;
    pwdata = v;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_reg(idx, v);
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic settle();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic set_center(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    reg_write(REG_CX, x);
    reg_write(REG_CY, y);
    reg_write(REG_CZ, z);
  endtask

  task automatic send_charge(c2m_in_t c);
    if (!quiet && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 12)) @(negedge clk_i);
    in_item_i = c;
    start = 1'b1;
    do @(posedge clk_i); while (busy);
    sb.note_charge(c);
    @(negedge clk_i);
    start = 1'b0;
  endtask

  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'h8000_0000;
      2: return 32'h7FFF_FFFF;
      default: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
    endcase
  endfunction

  function automatic c2m_in_t rnd_charge();
    c2m_in_t c;
    c.pos_x = rnd_coord();
    c.pos_y = rnd_coord();
    c.pos_z = rnd_coord();
    c.is_placeholder = ($urandom_range(0, 9) == 0);
    c.final_charge = 1'($urandom_range(0, 1));
    return c;
  endfunction

  function automatic c2m_in_t mk_charge(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                        logic ph, logic fin);
    c2m_in_t c;
    c.pos_x = x;
    c.pos_y = y;
    c.pos_z = z;
    c.is_placeholder = ph;
    c.final_charge = fin;
    return c;
  endfunction

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    // directed: reset settings first
    send_charge(mk_charge(32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000, 1'b0, 1'b1));
    send_charge(mk_charge(32'd0, 32'd0, 32'd0, 1'b0, 1'b0));
    send_charge(mk_charge(32'd0, 32'd0, 32'h0003_8000, 1'b0, 1'b1));
    send_charge(mk_charge(32'h1234_5678, 32'h8765_4321, 32'h0F0F_0F0F, 1'b1, 1'b1));
    settle();
    reg_write(REG_ORDER, 32'd7);
    send_charge(mk_charge(32'h0000_8000, 32'hFFFF_4000, 32'h0000_C000, 1'b0, 1'b1));
    send_charge(mk_charge(32'd0, 32'd0, 32'd0, 1'b0, 1'b0));
    send_charge(mk_charge(32'd0, 32'd0, 32'hFFFE_0000, 1'b0, 1'b0));
    send_charge(mk_charge(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b1));
    send_charge(mk_charge(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0));
    send_charge(mk_charge(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 1'b1, 1'b1));
    settle();
    reg_write(REG_ORDER, 32'd0);
    set_center(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
    send_charge(mk_charge(32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 1'b0, 1'b1));
    send_charge(mk_charge(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 1'b0, 1'b0));
    settle();
    reg_write(REG_ORDER, 32'd1);
    set_center(32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000);
    send_charge(mk_charge(32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 1'b0, 1'b1));
    send_charge(mk_charge(32'h0003_0000, 32'h0000_0000, 32'h0000_8000, 1'b0, 1'b0));
    settle();
    // random phases, mostly small orders
    for (int ph = 0; ph < 8; ph++) begin
      reg_write(REG_ORDER, (ph % 4 == 3) ? 32'd7 : 32'($urandom_range(0, 4)));
      if (ph % 2 == 1) set_center(rnd_coord(), rnd_coord(), rnd_coord());
      quiet = (ph == 7);
      for (int i = 0; i < 13; i++) send_charge(rnd_charge());
      settle();
    end
    $display("Covered %0d charges and %0d coefficient beats over orders 0..7.",
             sb.charges, sb.beats);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
